FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge, skipping cycles in reset.
`define CTSW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define CTSW_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/core/ctsw_pkg.sv
// Types and constants of the countdown timer and stopwatch controller.
package ctsw_pkg;

    typedef enum logic [3:0] {
        REQ_TICK       = 4'd0,
        REQ_BTN1       = 4'd1,
        REQ_BTN2       = 4'd2,
        REQ_BTN3       = 4'd3,
        REQ_TMR_DONE   = 4'd4,
        REQ_TMR_START  = 4'd5,
        REQ_TMR_STOP   = 4'd6,
        REQ_TMR_RESET  = 4'd7,
        REQ_SW_START   = 4'd8,
        REQ_SW_STOP    = 4'd9,
        REQ_SW_RESET   = 4'd10,
        REQ_SET_PRESET = 4'd11
    } req_t;

    localparam logic [2:0]  MODE_CLOCK      = 3'd0;
    localparam logic [2:0]  MODE_TIMER      = 3'd1;
    localparam logic [2:0]  MODE_STOPWATCH  = 3'd2;
    localparam logic [2:0]  MODE_COLOR_DEMO = 3'd3;
    localparam logic [2:0]  MODE_LAST       = 3'd4;

    localparam logic [31:0] MS_PER_SEC  = 32'd1000;
    localparam logic [22:0] PRESET_STEP = 23'd60;
    localparam logic [22:0] PRESET_CAP  = 23'd4294967;

    typedef struct packed {
        logic [2:0]  mode;
        logic [22:0] preset_secs;
        logic        timer_run;
        logic [31:0] timer_left;
        logic [31:0] timer_start_time;
        logic [31:0] timer_start_left;
        logic        sw_run;
        logic [31:0] sw_accum;
        logic [31:0] sw_start_time;
    } ctsw_state_t;

endpackage

FILE: rtl/core/countdown_timer_stopwatch_ctrl.sv
// Top level: event-driven countdown timer and stopwatch controller.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+----------------------------------------
//  event   | in        | in_valid / in_ready | req_type, now_ms, preset_value
//  status  | out       | out_valid/out_ready | mode_now, timer_*, stopwatch_*, display_changed
//
// One word per cycle while the status side is not stalled: an accepted event
// sits in the input register, and the single-pass update writes the controller
// state and the status register together as the event moves forward.
// Reset (rst_n, async, active low) clears the state to clock mode, all stopped.
// A stalled status word holds the event in the input register; accept a new
// event whenever that register is empty or moves forward this cycle.
module countdown_timer_stopwatch_ctrl (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  req_type,
    input  logic [31:0] now_ms,
    input  logic [22:0] preset_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  mode_now,
    output logic        timer_active,
    output logic [31:0] timer_left_ms,
    output logic [22:0] timer_preset_now,
    output logic        stopwatch_active,
    output logic [31:0] stopwatch_ms,
    output logic        display_changed
);

    // Input register
    logic        in_vld_reg;
    logic [3:0]  req_reg;
    logic [31:0] now_reg;
    logic [22:0] pval_reg;

    // Controller state
    ctsw_pkg::ctsw_state_t st_reg;
    ctsw_pkg::ctsw_state_t st_next;

    // Status register
    logic        out_vld_reg;
    logic [2:0]  mode_out_reg;
    logic        tmr_act_reg;
    logic [31:0] tmr_left_reg;
    logic [22:0] preset_out_reg;
    logic        sw_act_reg;
    logic [31:0] sw_ms_reg;
    logic        chg_reg;

    logic        advance;
    logic        chg_next;
    logic [31:0] sw_ms_next;

    // Arithmetic shared by several events
    logic [31:0] tmr_elapsed;
    logic [31:0] sw_elapsed;
    logic [31:0] tmr_remain;
    logic        tmr_expired;
    logic [31:0] preset_ms;
    logic [23:0] preset_up;
    logic [22:0] preset_inc;
    logic [22:0] preset_dec;
    logic [22:0] preset_set;
    logic [22:0] load_secs;
    logic [31:0] load_ms;
    logic [31:0] start_left;

    // Move the pending event forward when the status register is free
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    assign tmr_elapsed = now_reg - st_reg.timer_start_time;
    assign tmr_expired = tmr_elapsed >= st_reg.timer_start_left;
    assign tmr_remain  = st_reg.timer_start_left - tmr_elapsed;
    assign sw_elapsed  = now_reg - st_reg.sw_start_time;
    assign preset_ms   = {9'd0, st_reg.preset_secs} * ctsw_pkg::MS_PER_SEC;

    // Saturate at the cap so that the preset in ms fits 32 bits
    assign preset_up  = {1'b0, st_reg.preset_secs} + {1'b0, ctsw_pkg::PRESET_STEP};
    assign preset_inc = (preset_up > {1'b0, ctsw_pkg::PRESET_CAP}) ?
                        ctsw_pkg::PRESET_CAP : preset_up[22:0];
    assign preset_dec = (st_reg.preset_secs >= ctsw_pkg::PRESET_STEP) ?
                        (st_reg.preset_secs - ctsw_pkg::PRESET_STEP) : 23'd0;
    assign preset_set = (pval_reg > ctsw_pkg::PRESET_CAP) ? ctsw_pkg::PRESET_CAP : pval_reg;

    // One multiplier serves every preset change (BTN2, BTN3, SET_PRESET)
    always_comb
    begin
        case (req_reg)
            ctsw_pkg::REQ_BTN2:       load_secs = preset_inc;
            ctsw_pkg::REQ_BTN3:       load_secs = preset_dec;
            ctsw_pkg::REQ_SET_PRESET: load_secs = preset_set;
            default:                  load_secs = st_reg.preset_secs;
        endcase
    end

    assign load_ms    = {9'd0, load_secs} * ctsw_pkg::MS_PER_SEC;
    // Timer start reloads from the preset only when nothing is left
    assign start_left = (st_reg.timer_left == 32'd0) ? preset_ms : st_reg.timer_left;

    // Next controller state for the event in the input register
    always_comb
    begin
        st_next  = st_reg;
        chg_next = 1'b1;
        case (req_reg)
            ctsw_pkg::REQ_TICK:
            begin
                if (!st_reg.timer_run) begin
                    chg_next = 1'b0;
                end else if (tmr_expired) begin
                    st_next.timer_run  = 1'b0;
                    st_next.timer_left = 32'd0;
                end else if (tmr_remain != st_reg.timer_left) begin
                    st_next.timer_left = tmr_remain;
                end else begin
                    chg_next = 1'b0;
                end
            end
            ctsw_pkg::REQ_BTN1:
            begin
                st_next.mode = (st_reg.mode == ctsw_pkg::MODE_LAST) ?
                               ctsw_pkg::MODE_CLOCK : (st_reg.mode + 3'd1);
            end
            ctsw_pkg::REQ_BTN2:
            begin
                if (st_reg.mode == ctsw_pkg::MODE_TIMER) begin
                    st_next.preset_secs = load_secs;
                    st_next.timer_left  = load_ms;
                    st_next.timer_run   = 1'b0;
                end else if (st_reg.mode == ctsw_pkg::MODE_STOPWATCH) begin
                    // Toggle: stop and bank the lap, or start timing
                    if (st_reg.sw_run) begin
                        st_next.sw_accum = st_reg.sw_accum + sw_elapsed;
                        st_next.sw_run   = 1'b0;
                    end else begin
                        st_next.sw_run        = 1'b1;
                        st_next.sw_start_time = now_reg;
                    end
                end else begin
                    st_next.mode = ctsw_pkg::MODE_CLOCK;
                end
            end
            ctsw_pkg::REQ_BTN3:
            begin
                if (st_reg.mode == ctsw_pkg::MODE_TIMER) begin
                    st_next.preset_secs = load_secs;
                    st_next.timer_left  = load_ms;
                    st_next.timer_run   = 1'b0;
                end else if (st_reg.mode == ctsw_pkg::MODE_STOPWATCH) begin
                    st_next.sw_run        = 1'b0;
                    st_next.sw_accum      = 32'd0;
                    st_next.sw_start_time = now_reg;
                end else begin
                    st_next.mode = ctsw_pkg::MODE_COLOR_DEMO;
                end
            end
            ctsw_pkg::REQ_TMR_DONE:
            begin
                st_next.timer_run  = 1'b0;
                st_next.timer_left = 32'd0;
            end
            ctsw_pkg::REQ_TMR_START:
            begin
                st_next.mode             = ctsw_pkg::MODE_TIMER;
                st_next.timer_left       = start_left;
                st_next.timer_run        = (start_left != 32'd0);
                st_next.timer_start_time = now_reg;
                st_next.timer_start_left = start_left;
            end
            ctsw_pkg::REQ_TMR_STOP:
            begin
                if (st_reg.timer_run) begin
                    st_next.timer_left = tmr_expired ? 32'd0 : tmr_remain;
                    st_next.timer_run  = 1'b0;
                end else begin
                    chg_next = 1'b0;
                end
            end
            ctsw_pkg::REQ_TMR_RESET:
            begin
                st_next.timer_run  = 1'b0;
                st_next.timer_left = preset_ms;
            end
            ctsw_pkg::REQ_SW_START:
            begin
                st_next.mode = ctsw_pkg::MODE_STOPWATCH;
                if (!st_reg.sw_run) begin
                    st_next.sw_run        = 1'b1;
                    st_next.sw_start_time = now_reg;
                end
            end
            ctsw_pkg::REQ_SW_STOP:
            begin
                if (st_reg.sw_run) begin
                    st_next.sw_accum = st_reg.sw_accum + sw_elapsed;
                    st_next.sw_run   = 1'b0;
                end else begin
                    chg_next = 1'b0;
                end
            end
            ctsw_pkg::REQ_SW_RESET:
            begin
                st_next.sw_run        = 1'b0;
                st_next.sw_accum      = 32'd0;
                st_next.sw_start_time = now_reg;
            end
            ctsw_pkg::REQ_SET_PRESET:
            begin
                st_next.preset_secs = load_secs;
                st_next.timer_left  = load_ms;
                st_next.timer_run   = 1'b0;
            end
            default:
            begin
                // Unused codes: drop without effect
                chg_next = 1'b0;
            end
        endcase
    end

    // Live stopwatch reading at the event time, from the updated state
    assign sw_ms_next = st_next.sw_run ?
                        (st_next.sw_accum + (now_reg - st_next.sw_start_time)) :
                        st_next.sw_accum;

    // Input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (in_ready) begin
            in_vld_reg <= in_valid;
        end
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            req_reg  <= req_type;
            now_reg  <= now_ms;
            pval_reg <= preset_value;
        end
    end

    // Controller state: commit as the event moves to the status register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // Status register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (out_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    // Status register: payload
    always_ff @(posedge clk)
    begin
        if (advance) begin
            mode_out_reg   <= st_next.mode;
            tmr_act_reg    <= st_next.timer_run;
            tmr_left_reg   <= st_next.timer_left;
            preset_out_reg <= st_next.preset_secs;
            sw_act_reg     <= st_next.sw_run;
            sw_ms_reg      <= sw_ms_next;
            chg_reg        <= chg_next;
        end
    end

    assign out_valid        = out_vld_reg;
    assign mode_now         = mode_out_reg;
    assign timer_active     = tmr_act_reg;
    assign timer_left_ms    = tmr_left_reg;
    assign timer_preset_now = preset_out_reg;
    assign stopwatch_active = sw_act_reg;
    assign stopwatch_ms     = sw_ms_reg;
    assign display_changed  = chg_reg;

endmodule

FILE: rtl/core/ctsw_checker.sv
// Port-level checker for the timer and stopwatch controller, with its bind.
`include "assert_macros.svh"

module ctsw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  mode_now,
    input logic        timer_active,
    input logic [31:0] timer_left_ms,
    input logic [22:0] timer_preset_now,
    input logic [31:0] stopwatch_ms
);

    logic        stalled;
    logic [90:0] held_word;

    assign stalled   = out_valid && !out_ready;
    assign held_word = {mode_now, timer_active, timer_left_ms, timer_preset_now, stopwatch_ms};

    `CTSW_ASSERT(a_out_hold, stalled |=> out_valid && $stable(held_word), "stalled word changed")
    `CTSW_NEVER(a_mode_range, out_valid && (mode_now > ctsw_pkg::MODE_LAST), "mode out of range")
    `CTSW_NEVER(a_preset_cap, out_valid && (timer_preset_now > ctsw_pkg::PRESET_CAP), "over cap")
    `CTSW_NEVER(a_run_nonzero, out_valid && timer_active && timer_left_ms == '0, "run at zero")

endmodule

bind countdown_timer_stopwatch_ctrl ctsw_checker u_ctsw_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mode_now         (mode_now),
    .timer_active     (timer_active),
    .timer_left_ms    (timer_left_ms),
    .timer_preset_now (timer_preset_now),
    .stopwatch_ms     (stopwatch_ms)
);

FILE: tb/countdown_timer_stopwatch_ctrl_checker.sv
// Checker for the timer and stopwatch controller: predicts each status word and compares it.
`timescale 1ns / 100ps

module countdown_timer_stopwatch_ctrl_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  req_type,
    input  logic [31:0] now_ms,
    input  logic [22:0] preset_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  mode_now,
    input  logic        timer_active,
    input  logic [31:0] timer_left_ms,
    input  logic [22:0] timer_preset_now,
    input  logic        stopwatch_active,
    input  logic [31:0] stopwatch_ms,
    input  logic        display_changed,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [2:0]  mode;
        logic        tmr_on;
        logic [31:0] tmr_left;
        logic [22:0] preset;
        logic        sw_on;
        logic [31:0] sw_ms;
        logic        redraw;
    } status_t;

    ctsw_pkg::ctsw_state_t ctl;
    status_t               status_q[$];
    int                    mismatches;

    function automatic string fmt_status(input status_t w);
        return $sformatf("mode=%0d tmr=%0b left=%0d preset=%0d sw=%0b sw_ms=%0d redraw=%0b",
                         w.mode, w.tmr_on, w.tmr_left, w.preset, w.sw_on, w.sw_ms, w.redraw);
    endfunction

    // Saturate at the cap, stop the countdown and reload it from the new preset.
    task automatic load_preset(input logic [31:0] secs);
        logic [31:0] capped;
        capped = (secs > {9'd0, ctsw_pkg::PRESET_CAP}) ? {9'd0, ctsw_pkg::PRESET_CAP} : secs;
        ctl.preset_secs = capped[22:0];
        ctl.timer_left  = capped * ctsw_pkg::MS_PER_SEC;
        ctl.timer_run   = 1'b0;
    endtask

    task automatic sw_begin(input logic [31:0] t);
        ctl.mode = ctsw_pkg::MODE_STOPWATCH;
        if (!ctl.sw_run)
        begin
            ctl.sw_run        = 1'b1;
            ctl.sw_start_time = t;
        end
    endtask

    task automatic sw_halt(input logic [31:0] t, output logic was_running);
        was_running = ctl.sw_run;
        if (ctl.sw_run)
        begin
            ctl.sw_accum = ctl.sw_accum + (t - ctl.sw_start_time);
            ctl.sw_run   = 1'b0;
        end
    endtask

    task automatic sw_clear(input logic [31:0] t);
        ctl.sw_run        = 1'b0;
        ctl.sw_accum      = '0;
        ctl.sw_start_time = t;
    endtask

    // Apply one event to the shadow state and build the status word it yields.
    task automatic apply_event(input logic [3:0] req, input logic [31:0] t,
                               input logic [22:0] pv, output status_t st);
        logic [31:0] elapsed;
        logic        changed;
        logic        ran;
        changed = 1'b1;
        elapsed = t - ctl.timer_start_time;
        case (req)
            ctsw_pkg::REQ_TICK:
                if (!ctl.timer_run)
                    changed = 1'b0;
                else if (elapsed >= ctl.timer_start_left)
                begin
                    ctl.timer_run  = 1'b0;
                    ctl.timer_left = '0;
                end
                else if (ctl.timer_start_left - elapsed != ctl.timer_left)
                    ctl.timer_left = ctl.timer_start_left - elapsed;
                else
                    changed = 1'b0;
            ctsw_pkg::REQ_BTN1:
                ctl.mode = (ctl.mode == ctsw_pkg::MODE_LAST) ?
                           ctsw_pkg::MODE_CLOCK : ctl.mode + 3'd1;
            ctsw_pkg::REQ_BTN2:
                if (ctl.mode == ctsw_pkg::MODE_TIMER)
                    load_preset({9'd0, ctl.preset_secs} + {9'd0, ctsw_pkg::PRESET_STEP});
                else if (ctl.mode == ctsw_pkg::MODE_STOPWATCH)
                begin
                    if (ctl.sw_run)
                        sw_halt(t, ran);
                    else
                        sw_begin(t);
                end
                else
                    ctl.mode = ctsw_pkg::MODE_CLOCK;
            ctsw_pkg::REQ_BTN3:
                if (ctl.mode == ctsw_pkg::MODE_TIMER)
                    load_preset(ctl.preset_secs >= ctsw_pkg::PRESET_STEP ?
                                {9'd0, ctl.preset_secs - ctsw_pkg::PRESET_STEP} : 32'd0);
                else if (ctl.mode == ctsw_pkg::MODE_STOPWATCH)
                    sw_clear(t);
                else
                    ctl.mode = ctsw_pkg::MODE_COLOR_DEMO;
            ctsw_pkg::REQ_TMR_DONE:
            begin
                ctl.timer_run  = 1'b0;
                ctl.timer_left = '0;
            end
            ctsw_pkg::REQ_TMR_START:
            begin
                ctl.mode = ctsw_pkg::MODE_TIMER;
                if (ctl.timer_left == '0)
                    ctl.timer_left = {9'd0, ctl.preset_secs} * ctsw_pkg::MS_PER_SEC;
                ctl.timer_run        = (ctl.timer_left != '0);
                ctl.timer_start_time = t;
                ctl.timer_start_left = ctl.timer_left;
            end
            ctsw_pkg::REQ_TMR_STOP:
                if (ctl.timer_run)
                begin
                    ctl.timer_left = (elapsed >= ctl.timer_start_left) ?
                                     32'd0 : ctl.timer_start_left - elapsed;
                    ctl.timer_run  = 1'b0;
                end
                else
                    changed = 1'b0;
            ctsw_pkg::REQ_TMR_RESET:
            begin
                ctl.timer_run  = 1'b0;
                ctl.timer_left = {9'd0, ctl.preset_secs} * ctsw_pkg::MS_PER_SEC;
            end
            ctsw_pkg::REQ_SW_START:
                sw_begin(t);
            ctsw_pkg::REQ_SW_STOP:
            begin
                sw_halt(t, ran);
                changed = ran;
            end
            ctsw_pkg::REQ_SW_RESET:
                sw_clear(t);
            ctsw_pkg::REQ_SET_PRESET:
                load_preset({9'd0, pv});
            default:
                changed = 1'b0;
        endcase
        st.mode     = ctl.mode;
        st.tmr_on   = ctl.timer_run;
        st.tmr_left = ctl.timer_left;
        st.preset   = ctl.preset_secs;
        st.sw_on    = ctl.sw_run;
        st.sw_ms    = ctl.sw_run ? ctl.sw_accum + (t - ctl.sw_start_time) : ctl.sw_accum;
        st.redraw   = changed;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        status_t exp_w;
        status_t got_w;
        string   diff;
        if (!rst_n)
        begin
            ctl = '0;
            status_q.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            // Compare the outgoing word before queuing the incoming event's prediction.
            if (out_valid && out_ready)
            begin
                got_w.mode     = mode_now;
                got_w.tmr_on   = timer_active;
                got_w.tmr_left = timer_left_ms;
                got_w.preset   = timer_preset_now;
                got_w.sw_on    = stopwatch_active;
                got_w.sw_ms    = stopwatch_ms;
                got_w.redraw   = display_changed;
                if (status_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: status word with no event pending: mode=%0d left=%0d",
                                 $realtime, mode_now, timer_left_ms);
                end
                else
                begin
                    exp_w = status_q.pop_front();
                    diff  = "";
                    if (got_w.mode !== exp_w.mode)         diff = {diff, " mode_now"};
                    if (got_w.tmr_on !== exp_w.tmr_on)     diff = {diff, " timer_active"};
                    if (got_w.tmr_left !== exp_w.tmr_left) diff = {diff, " timer_left_ms"};
                    if (got_w.preset !== exp_w.preset)     diff = {diff, " timer_preset_now"};
                    if (got_w.sw_on !== exp_w.sw_on)       diff = {diff, " stopwatch_active"};
                    if (got_w.sw_ms !== exp_w.sw_ms)       diff = {diff, " stopwatch_ms"};
                    if (got_w.redraw !== exp_w.redraw)     diff = {diff, " display_changed"};
                    if (diff != "")
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: status mismatch in%s", $realtime, diff);
                            $display("  expected %s", fmt_status(exp_w));
                            $display("  actual   %s", fmt_status(got_w));
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                apply_event(req_type, now_ms, preset_value, exp_w);
                status_q.push_back(exp_w);
            end
            fail_count    <= mismatches;
            pending_count <= status_q.size();
        end
    end

endmodule

FILE: tb/countdown_timer_stopwatch_ctrl_tb.sv
// Testbench top for the timer and stopwatch controller: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module countdown_timer_stopwatch_ctrl_tb;

    // Number of random event words after the directed opening.
    localparam int RANDOM_EVENTS = 1100;
    // Highest request code; the codes above the preset write are unused.
    localparam logic [3:0] REQ_CODE_MAX = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  req_type;
    logic [31:0] now_ms;
    logic [22:0] preset_value;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  mode_now;
    logic        timer_active;
    logic [31:0] timer_left_ms;
    logic [22:0] timer_preset_now;
    logic        stopwatch_active;
    logic [31:0] stopwatch_ms;
    logic        display_changed;

    int          fail_count;
    int          pending_count;
    // Percent of cycles in which the sender idles / the receiver stalls.
    int          idle_pct;
    int          stall_pct;
    int          events_sent;
    // Free-running millisecond time carried from event to event.
    logic [31:0] clock_ms;

    countdown_timer_stopwatch_ctrl dut (.*);

    countdown_timer_stopwatch_ctrl_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Backstop: a healthy run ends far earlier than this.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drive the status back-pressure; a fresh draw every cycle.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Hand one event word to the block: idle at random first, then hold valid
    // with a steady payload until the block takes the word.
    task automatic send_event(input logic [3:0] req, input logic [31:0] t,
                              input logic [22:0] pv);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        now_ms       <= t;
        preset_value <= pv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;
    endtask

    // Advance the event time: mostly small steps, now and then a jump or a
    // position just short of the 32-bit wrap.
    function automatic logic [31:0] next_ms();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            clock_ms = $urandom;
        else if (roll < 4)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        else
            clock_ms = clock_ms + $urandom_range(0, 1200);
        return clock_ms;
    endfunction

    // Pick a preset: mostly a few seconds so countdowns finish, sometimes
    // anywhere up to the cap, near the cap, or above it.
    function automatic logic [22:0] pick_preset();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 23'($urandom_range(0, 5));
            6:                return 23'($urandom_range(0, ctsw_pkg::PRESET_CAP));
            7:                return ctsw_pkg::PRESET_CAP - 23'($urandom_range(0, 120));
            8:                return 23'($urandom_range(ctsw_pkg::PRESET_CAP, 23'h7F_FFFF));
            default:          return 23'($urandom);
        endcase
    endfunction

    initial
    begin
        int         base;
        int         phase;
        int         steps;
        logic [3:0] req;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = ctsw_pkg::REQ_TICK;
        now_ms       = '0;
        preset_value = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        events_sent  = 0;
        clock_ms     = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening, no idling on either side.
        send_event(ctsw_pkg::REQ_TICK, 32'd0, 23'd0); // tick with the timer stopped
        send_event(ctsw_pkg::REQ_SET_PRESET, 32'd1, 23'h7F_FFFF); // above the cap: saturate
        send_event(ctsw_pkg::REQ_BTN1, 32'd2, 23'd0); // clock -> timer mode
        send_event(ctsw_pkg::REQ_BTN2, 32'd3, 23'd0); // +60 s held at the cap
        send_event(ctsw_pkg::REQ_SET_PRESET, 32'd4, 23'd59);
        send_event(ctsw_pkg::REQ_BTN3, 32'd5, 23'd0); // -60 s floors at zero
        send_event(ctsw_pkg::REQ_TMR_START, 32'd10, 23'd0); // zero preset: stays stopped
        send_event(ctsw_pkg::REQ_TMR_STOP, 32'd20, 23'd0); // stop while stopped
        send_event(ctsw_pkg::REQ_BTN2, 32'd30, 23'd0); // preset 60 s
        send_event(ctsw_pkg::REQ_TMR_START, 32'd100, 23'd0);
        send_event(ctsw_pkg::REQ_TICK, 32'd1600, 23'd0); // countdown moves
        send_event(ctsw_pkg::REQ_TICK, 32'd1600, 23'd0); // same time: no redraw
        send_event(ctsw_pkg::REQ_TMR_STOP, 32'd2100, 23'd0); // hold the remainder
        send_event(ctsw_pkg::REQ_TMR_START, 32'hFFFF_F000, 23'd0); // resume from the remainder
        send_event(ctsw_pkg::REQ_TICK, 32'h0010_0000, 23'd0); // past zero across the wrap
        send_event(ctsw_pkg::REQ_TMR_RESET, 32'h0010_0001, 23'd0);
        send_event(ctsw_pkg::REQ_TMR_DONE, 32'h0010_0002, 23'd0);
        send_event(ctsw_pkg::REQ_SW_START, 32'hFFFF_FF00, 23'd0);
        send_event(ctsw_pkg::REQ_TICK, 32'h0000_0100, 23'd0); // elapsed time wraps
        send_event(ctsw_pkg::REQ_BTN2, 32'h0000_0400, 23'd0); // stopwatch mode: stop
        send_event(ctsw_pkg::REQ_SW_STOP, 32'h0000_0500, 23'd0); // stop while stopped
        send_event(ctsw_pkg::REQ_BTN3, 32'h0000_0600, 23'd0); // stopwatch mode: clear
        send_event(ctsw_pkg::REQ_SW_RESET, 32'hFFFF_FFFF, 23'd0);
        send_event(ctsw_pkg::REQ_BTN1, 32'd0, 23'd0); // -> color demo
        send_event(ctsw_pkg::REQ_BTN2, 32'd0, 23'd0); // other mode: back to clock
        send_event(ctsw_pkg::REQ_BTN3, 32'd0, 23'd0); // other mode: color demo
        send_event(ctsw_pkg::REQ_BTN1, 32'd0, 23'd0); // -> last mode
        send_event(ctsw_pkg::REQ_BTN1, 32'd0, 23'd0); // wrap to clock
        send_event(REQ_CODE_MAX, 32'd0, 23'h7F_FFFF); // unused code

        // Random part in four idling phases: none, sender idle, receiver
        // stalling, then both lightly.
        base = events_sent;
        while (events_sent - base < RANDOM_EVENTS)
        begin
            phase = (events_sent - base) * 4 / RANDOM_EVENTS;
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 81;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 81;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase

            case ($urandom_range(0, 19))
                // Countdown run: load a preset, start, then mostly ticks with
                // the odd stop, restart, done, reset or preset button.
                0, 1, 2, 3, 4, 5, 6, 7:
                begin
                    send_event(ctsw_pkg::REQ_SET_PRESET, next_ms(), pick_preset());
                    send_event(ctsw_pkg::REQ_TMR_START, next_ms(), 23'($urandom));
                    steps = $urandom_range(2, 10);
                    repeat (steps)
                    begin
                        case ($urandom_range(0, 19))
                            0:       req = ctsw_pkg::REQ_TMR_STOP;
                            1:       req = ctsw_pkg::REQ_TMR_START;
                            2:       req = ctsw_pkg::REQ_TMR_DONE;
                            3:       req = ctsw_pkg::REQ_TMR_RESET;
                            4:       req = ctsw_pkg::REQ_BTN2;
                            5:       req = ctsw_pkg::REQ_BTN3;
                            default: req = ctsw_pkg::REQ_TICK;
                        endcase
                        send_event(req, next_ms(), 23'($urandom));
                    end
                end
                // Stopwatch session driven by requests and by the buttons.
                8, 9, 10, 11, 12:
                begin
                    send_event(ctsw_pkg::REQ_SW_START, next_ms(), 23'($urandom));
                    steps = $urandom_range(2, 10);
                    repeat (steps)
                    begin
                        case ($urandom_range(0, 13))
                            0:       req = ctsw_pkg::REQ_SW_STOP;
                            1:       req = ctsw_pkg::REQ_SW_START;
                            2:       req = ctsw_pkg::REQ_SW_RESET;
                            3:       req = ctsw_pkg::REQ_BTN3;
                            4, 5:    req = ctsw_pkg::REQ_BTN2;
                            6:       req = ctsw_pkg::REQ_BTN1;
                            default: req = ctsw_pkg::REQ_TICK;
                        endcase
                        send_event(req, next_ms(), 23'($urandom));
                    end
                end
                // Noise: any code, any time.
                default:
                    send_event(4'($urandom_range(0, REQ_CODE_MAX)),
                               ($urandom_range(0, 4) == 0) ? 32'($urandom) : next_ms(),
                               pick_preset());
            endcase
        end

        // Drop valid, wait for every predicted word, then let the pipe settle.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ctsw_pkg.sv
rtl/core/countdown_timer_stopwatch_ctrl.sv
rtl/core/ctsw_checker.sv
tb/countdown_timer_stopwatch_ctrl_checker.sv
tb/countdown_timer_stopwatch_ctrl_tb.sv
